FILE: rtl/core/grc_pkg.sv
// Shared types and constants for the grid ray-cast column block.
// Holds the channel payload structs, register and face codes and divider sizes.
// No dependencies.
package grc_pkg;

    // Input command codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_POS_X    = 3'd0;
    localparam logic [2:0] REG_POS_Y    = 3'd1;
    localparam logic [2:0] REG_DIR_X    = 3'd2;
    localparam logic [2:0] REG_DIR_Y    = 3'd3;
    localparam logic [2:0] REG_PLANE_X  = 3'd4;
    localparam logic [2:0] REG_PLANE_Y  = 3'd5;
    localparam logic [2:0] REG_SCREEN_W = 3'd6;
    localparam logic [2:0] REG_SCREEN_H = 3'd7;

    // Wall face codes
    localparam logic [1:0] FACE_WEST  = 2'd0;
    localparam logic [1:0] FACE_EAST  = 2'd1;
    localparam logic [1:0] FACE_NORTH = 2'd2;
    localparam logic [1:0] FACE_SOUTH = 2'd3;

    // Datapath widths
    localparam int ONE_Q16  = 65536;
    localparam int CAM_W    = 30;   // camera offset, signed Q16
    localparam int PROD_W   = 49;   // plane times camera product
    localparam int RD_W     = 34;   // ray direction, signed Q16
    localparam int DELTA_W  = 41;   // delta distance, up to 2^40
    localparam int SD_W     = 52;   // accumulated side distance
    localparam int CELL_W   = 10;   // signed map coordinate
    localparam int NUM_W    = 28;   // signed offset to crossed grid line

    // Shared divider sizes
    localparam int DIV_NW = 42;
    localparam int DIV_DW = 34;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    typedef struct packed {
        logic        op;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic        wall;
        logic [10:0] column;
    } cmd_t;

    typedef struct packed {
        logic [10:0] out_column;
        logic        hit;
        logic [1:0]  face;
        logic [23:0] perp_dist;
        logic [15:0] line_height;
        logic [10:0] draw_start;
        logic [10:0] draw_end;
        logic [5:0]  tex_x;
        logic [21:0] tex_step;
        logic [31:0] tex_pos;
    } res_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [21:0] value;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quot;
    } div_rsp_t;

endpackage

FILE: rtl/core/grc_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
// Payload type is given at instantiation; used with grc_pkg structs.
interface grc_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/grc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module grc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/core/grc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on grc_pkg for request and response structs.
module grc_div
    import grc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [DIV_NW-1:0] dvd_reg;
    logic [DIV_DW-1:0] dsr_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIV_NW-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = trial >= {1'b0, dsr_reg};
    end

    // Control: count the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CW'(DIV_NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            dvd_reg <= {dvd_reg[DIV_NW-2:0], ge};
        end
    end

    assign rsp = '{busy: busy_reg, done: done_reg, quot: dvd_reg};
endmodule

FILE: rtl/core/grid_ray_cast_column_top.sv
// Column raycaster over a one-bit wall map with a DDA grid walk.
// Channels: cmd (sink) takes op 0 map writes and op 1 column casts; res
// (source) gives one result beat per cast; cfg (sink) writes the camera and
// screen registers and is always ready.
// A map write gives no result. A cast runs a sequencer around one shared
// divider (up to six divisions: camera, two deltas, distance, line height,
// texture step), a walk that spends a step state and a check state on each
// cell, since the map memory's read is registered, and 13 further steps.
// One cast at a time.
// The result sits in an output register, so the next command is taken while
// a stalled result waits; a cast that finishes while the register is full
// holds until the receiver takes the waiting beat.
// After reset the map memory is cleared one cell a cycle, all MAP_DIM * MAP_DIM
// cells (4096 by default), during which cmd is not ready.
// Depends on grc_pkg, grc_chan_if, grc_ram and grc_div.
module grid_ray_cast_column_top
    import grc_pkg::*;
#(
    parameter int MAP_DIM   = 64,
    parameter int TEX_SIZE  = 64,
    parameter int MAX_STEPS = 128
) (
    input logic        clk,
    input logic        rst_n,
    grc_chan_if.sink   cmd,
    grc_chan_if.source res,
    grc_chan_if.sink   cfg
);
    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int N_W   = $clog2(MAX_STEPS + 1);
    localparam logic signed [CELL_W-1:0] MAP_LIM  = CELL_W'(MAP_DIM);
    localparam logic [DIV_NW-1:0]        TEX_NUM  = DIV_NW'(TEX_SIZE) << 16;
    localparam logic [DIV_NW-1:0]        DDA_NUM  = DIV_NW'(1) << 32;
    localparam logic [DELTA_W-1:0]       DELTA_SAT = DELTA_W'(1) << 40;

    // Sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CAM  = 5'd1;
    localparam logic [4:0] S_RAYX = 5'd2;
    localparam logic [4:0] S_RAYY = 5'd3;
    localparam logic [4:0] S_RAYD = 5'd4;
    localparam logic [4:0] S_DDX  = 5'd5;
    localparam logic [4:0] S_DDYS = 5'd6;
    localparam logic [4:0] S_DDY  = 5'd7;
    localparam logic [4:0] S_SDX  = 5'd8;
    localparam logic [4:0] S_SDXA = 5'd9;
    localparam logic [4:0] S_SDY  = 5'd10;
    localparam logic [4:0] S_SDYA = 5'd11;
    localparam logic [4:0] S_STEP = 5'd12;
    localparam logic [4:0] S_CHK  = 5'd13;
    localparam logic [4:0] S_NUM  = 5'd14;
    localparam logic [4:0] S_PERP = 5'd15;
    localparam logic [4:0] S_LHS  = 5'd16;
    localparam logic [4:0] S_LH   = 5'd17;
    localparam logic [4:0] S_TSS  = 5'd18;
    localparam logic [4:0] S_TS   = 5'd19;
    localparam logic [4:0] S_TEX  = 5'd20;
    localparam logic [4:0] S_FIN  = 5'd21;

    // Configuration registers
    logic [21:0]        pos_x_reg, pos_y_reg;
    logic signed [18:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [11:0]        screen_w_reg, screen_h_reg;

    // Control
    logic [4:0]    state_reg;
    logic          start_reg;
    logic          start_next;
    logic          out_valid_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Datapath
    logic [DIV_NW-1:0]        dreq_dvd_reg;
    logic [DIV_DW-1:0]        dreq_dsr_reg;
    logic [10:0]              column_reg;
    logic signed [CAM_W-1:0]  cam_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RD_W-1:0]   rdx_reg, rdy_reg;
    logic [DELTA_W-1:0]       ddx_reg, ddy_reg;
    logic [41:0]              phi_reg;
    logic [32:0]              plo_reg;
    logic [SD_W-1:0]          sdx_reg, sdy_reg;
    logic signed [CELL_W-1:0] mx_reg, my_reg;
    logic                     side_reg, hit_reg, oob_reg;
    logic [N_W-1:0]           n_reg;
    logic [1:0]               face_reg;
    logic [23:0]              perp_reg;
    logic [15:0]              lh_reg;
    logic [21:0]              tstep_reg;
    logic [10:0]              ds_reg, de_reg;
    logic [14:0]              term_reg;
    logic [31:0]              wprod_reg;
    logic [5:0]               tx_reg;
    logic [36:0]              tpos_prod_reg;
    res_t                     res_reg;

    // Shared units
    div_req_t      div_req;
    div_rsp_t      div_rsp;
    logic          map_we;
    logic [AW-1:0] map_waddr, map_raddr;
    logic [0:0]    map_wdata, map_rdata;

    // Combinational helpers
    logic                     cmd_acc, wr_in_range;
    logic [11:0]              w_eff, h_eff;
    logic                     rdx_neg, rdy_neg;
    logic [RD_W-1:0]          rdx_abs, rdy_abs;
    logic [16:0]              fxs_x, fxs_y, mul_f;
    logic [DELTA_W-1:0]       mul_d;
    logic                     take_x, oob_n;
    logic signed [CELL_W-1:0] mx_n, my_n, m_sel;
    logic [21:0]              p_sel, p_oth;
    logic                     neg_sel;
    logic signed [NUM_W-1:0]  num_n;
    logic [NUM_W-1:0]         num_abs;
    logic [RD_W-1:0]          rd_abs_sel;
    logic                     rd_zero_sel;
    logic [1:0]               face_n;
    logic [10:0]              hh;
    logic [14:0]              lh2;
    logic [15:0]              de_sum;
    logic [15:0]              frac;
    logic [24:0]              tx_prod;
    logic [8:0]               tx_raw, tx_mir;
    logic [31:0]              wmul_b;

    assign cmd_acc = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE) && !clr_busy_reg;
    assign cfg.ready = 1'b1;
    assign res.valid = out_valid_reg;
    assign res.data  = res_reg;

    // Clamp screen sizes, build ray magnitudes and side-distance operands
    always_comb
    begin
        w_eff = (screen_w_reg == 12'd0) ? 12'd1 :
                (screen_w_reg > 12'd2048) ? 12'd2048 : screen_w_reg;
        h_eff = (screen_h_reg == 12'd0) ? 12'd1 :
                (screen_h_reg > 12'd2048) ? 12'd2048 : screen_h_reg;
        rdx_neg = rdx_reg[RD_W-1];
        rdy_neg = rdy_reg[RD_W-1];
        rdx_abs = rdx_neg ? RD_W'(-rdx_reg) : RD_W'(rdx_reg);
        rdy_abs = rdy_neg ? RD_W'(-rdy_reg) : RD_W'(rdy_reg);
        fxs_x = rdx_neg ? {1'b0, pos_x_reg[15:0]} : 17'(ONE_Q16) - {1'b0, pos_x_reg[15:0]};
        fxs_y = rdy_neg ? {1'b0, pos_y_reg[15:0]} : 17'(ONE_Q16) - {1'b0, pos_y_reg[15:0]};
        mul_f = (state_reg == S_SDX) ? fxs_x : fxs_y;
        mul_d = (state_reg == S_SDX) ? ddx_reg : ddy_reg;
    end

    // Next DDA cell and its map address
    always_comb
    begin
        take_x = sdx_reg < sdy_reg;
        mx_n = mx_reg;
        my_n = my_reg;
        if (take_x)
        begin
            mx_n = rdx_neg ? mx_reg - CELL_W'(1) : mx_reg + CELL_W'(1);
        end
        else
        begin
            my_n = rdy_neg ? my_reg - CELL_W'(1) : my_reg + CELL_W'(1);
        end
        oob_n = (mx_n < 0) || (my_n < 0) || (mx_n >= MAP_LIM) || (my_n >= MAP_LIM);
        map_raddr = AW'(my_n) * AW'(MAP_DIM) + AW'(mx_n);
    end

    // Offset to the crossed grid line, face and the span of the slice
    always_comb
    begin
        m_sel   = side_reg ? my_reg : mx_reg;
        p_sel   = side_reg ? pos_y_reg : pos_x_reg;
        p_oth   = side_reg ? pos_x_reg : pos_y_reg;
        neg_sel = side_reg ? rdy_neg : rdx_neg;
        num_n   = (NUM_W'(m_sel) <<< 16) - NUM_W'(p_sel)
                  + (neg_sel ? NUM_W'(ONE_Q16) : NUM_W'(0));
        num_abs = num_n[NUM_W-1] ? NUM_W'(-num_n) : NUM_W'(num_n);
        rd_abs_sel  = side_reg ? rdy_abs : rdx_abs;
        rd_zero_sel = side_reg ? (rdy_reg == '0) : (rdx_reg == '0);
        if (!side_reg)
        begin
            face_n = rdx_neg ? FACE_WEST : FACE_EAST;
        end
        else
        begin
            face_n = rdy_neg ? FACE_NORTH : FACE_SOUTH;
        end
        hh     = h_eff[11:1];
        lh2    = lh_reg[15:1];
        de_sum = 16'(lh2) + 16'(hh);
        wmul_b = side_reg ? rdx_reg[31:0] : rdy_reg[31:0];
        frac    = p_oth[15:0] + wprod_reg[31:16];
        tx_prod = 25'(frac) * 25'(TEX_SIZE);
        tx_raw  = tx_prod[24:16];
        tx_mir  = 9'(TEX_SIZE - 1) - tx_raw;
    end

    // Launch a division in the states that hand one to the divider
    always_comb
    begin
        case (state_reg)
            S_IDLE:  start_next = cmd_acc && (cmd.data.op == OP_CAST);
            S_RAYD:  start_next = (rdx_reg != '0);
            S_DDYS:  start_next = (rdy_reg != '0);
            S_NUM:   start_next = !rd_zero_sel;
            S_LHS:   start_next = (perp_reg != '0);
            S_TSS:   start_next = (lh_reg != '0);
            default: start_next = 1'b0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= 22'd163840;
            pos_y_reg    <= 22'd163840;
            dir_x_reg    <= -19'sd65536;
            dir_y_reg    <= 19'sd0;
            plane_x_reg  <= 19'sd0;
            plane_y_reg  <= 19'sd43254;
            screen_w_reg <= 12'd640;
            screen_h_reg <= 12'd480;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.data.index)
                REG_POS_X:    pos_x_reg    <= cfg.data.value;
                REG_POS_Y:    pos_y_reg    <= cfg.data.value;
                REG_DIR_X:    dir_x_reg    <= cfg.data.value[18:0];
                REG_DIR_Y:    dir_y_reg    <= cfg.data.value[18:0];
                REG_PLANE_X:  plane_x_reg  <= cfg.data.value[18:0];
                REG_PLANE_Y:  plane_y_reg  <= cfg.data.value[18:0];
                REG_SCREEN_W: screen_w_reg <= cfg.data.value[11:0];
                REG_SCREEN_H: screen_h_reg <= cfg.data.value[11:0];
                default: ;
            endcase
        end
    end

    // Clear the map after reset, one cell a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Map write port: clearing pass or an accepted write beat
    always_comb
    begin
        wr_in_range = (int'(cmd.data.cell_x) < MAP_DIM) && (int'(cmd.data.cell_y) < MAP_DIM);
        map_we    = clr_busy_reg || (cmd_acc && cmd.data.op == OP_WRITE && wr_in_range);
        map_waddr = clr_busy_reg ? clr_cnt_reg
                  : AW'(cmd.data.cell_y) * AW'(MAP_DIM) + AW'(cmd.data.cell_x);
        map_wdata = clr_busy_reg ? 1'b0 : cmd.data.wall;
    end

    grc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign div_req = '{start: start_reg, dividend: dreq_dvd_reg, divisor: dreq_dsr_reg};

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Cast sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
        end
        else
        begin
            start_reg <= start_next;
            // Drop the taken beat unless a new one replaces it this cycle
            if (res.valid && res.ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_acc && cmd.data.op == OP_CAST)
                    begin
                        column_reg   <= cmd.data.column;
                        dreq_dvd_reg <= DIV_NW'(cmd.data.column) << 17;
                        dreq_dsr_reg <= DIV_DW'(w_eff);
                        state_reg    <= S_CAM;
                    end
                end
                S_CAM:
                begin
                    if (div_rsp.done)
                    begin
                        cam_reg   <= $signed(CAM_W'(div_rsp.quot)) - CAM_W'(ONE_Q16);
                        state_reg <= S_RAYX;
                    end
                end
                S_RAYX:
                begin
                    prod_reg  <= PROD_W'(plane_x_reg) * PROD_W'(cam_reg);
                    state_reg <= S_RAYY;
                end
                S_RAYY:
                begin
                    rdx_reg   <= RD_W'(dir_x_reg) + RD_W'(prod_reg >>> 16);
                    prod_reg  <= PROD_W'(plane_y_reg) * PROD_W'(cam_reg);
                    state_reg <= S_RAYD;
                end
                S_RAYD:
                begin
                    rdy_reg <= RD_W'(dir_y_reg) + RD_W'(prod_reg >>> 16);
                    if (rdx_reg == '0)
                    begin
                        ddx_reg   <= DELTA_SAT;
                        state_reg <= S_DDYS;
                    end
                    else
                    begin
                        dreq_dvd_reg <= DDA_NUM;
                        dreq_dsr_reg <= rdx_abs;
                        state_reg    <= S_DDX;
                    end
                end
                S_DDX:
                begin
                    if (div_rsp.done)
                    begin
                        ddx_reg   <= DELTA_W'(div_rsp.quot);
                        state_reg <= S_DDYS;
                    end
                end
                S_DDYS:
                begin
                    if (rdy_reg == '0)
                    begin
                        ddy_reg   <= DELTA_SAT;
                        state_reg <= S_SDX;
                    end
                    else
                    begin
                        dreq_dvd_reg <= DDA_NUM;
                        dreq_dsr_reg <= rdy_abs;
                        state_reg    <= S_DDY;
                    end
                end
                S_DDY:
                begin
                    if (div_rsp.done)
                    begin
                        ddy_reg   <= DELTA_W'(div_rsp.quot);
                        state_reg <= S_SDX;
                    end
                end
                S_SDX, S_SDY:
                begin
                    phi_reg <= 42'(mul_f) * 42'(mul_d[DELTA_W-1:16]);
                    plo_reg <= 33'(mul_f) * 33'(mul_d[15:0]);
                    mx_reg  <= CELL_W'(pos_x_reg[21:16]);
                    my_reg  <= CELL_W'(pos_y_reg[21:16]);
                    n_reg    <= '0;
                    hit_reg  <= 1'b0;
                    side_reg <= 1'b0;
                    state_reg <= (state_reg == S_SDX) ? S_SDXA : S_SDYA;
                end
                S_SDXA:
                begin
                    sdx_reg   <= SD_W'(phi_reg) + SD_W'(plo_reg[32:16]);
                    state_reg <= S_SDY;
                end
                S_SDYA:
                begin
                    sdy_reg   <= SD_W'(phi_reg) + SD_W'(plo_reg[32:16]);
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (n_reg == N_W'(MAX_STEPS))
                    begin
                        state_reg <= S_NUM;
                    end
                    else
                    begin
                        if (take_x)
                        begin
                            sdx_reg  <= sdx_reg + SD_W'(ddx_reg);
                            side_reg <= 1'b0;
                        end
                        else
                        begin
                            sdy_reg  <= sdy_reg + SD_W'(ddy_reg);
                            side_reg <= 1'b1;
                        end
                        mx_reg    <= mx_n;
                        my_reg    <= my_n;
                        n_reg     <= n_reg + 1'b1;
                        oob_reg   <= oob_n;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (oob_reg || map_rdata[0])
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_NUM;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_NUM:
                begin
                    face_reg <= face_n;
                    if (rd_zero_sel)
                    begin
                        perp_reg  <= '1;
                        state_reg <= S_LHS;
                    end
                    else
                    begin
                        dreq_dvd_reg <= DIV_NW'({num_abs, 16'b0});
                        dreq_dsr_reg <= rd_abs_sel;
                        state_reg    <= S_PERP;
                    end
                end
                S_PERP:
                begin
                    if (div_rsp.done)
                    begin
                        perp_reg  <= (|div_rsp.quot[DIV_NW-1:24]) ? '1 : div_rsp.quot[23:0];
                        state_reg <= S_LHS;
                    end
                end
                S_LHS:
                begin
                    if (perp_reg == '0)
                    begin
                        lh_reg    <= '1;
                        state_reg <= S_TSS;
                    end
                    else
                    begin
                        dreq_dvd_reg <= DIV_NW'({h_eff, 16'b0});
                        dreq_dsr_reg <= DIV_DW'(perp_reg);
                        state_reg    <= S_LH;
                    end
                end
                S_LH:
                begin
                    if (div_rsp.done)
                    begin
                        lh_reg    <= (|div_rsp.quot[DIV_NW-1:16]) ? '1 : div_rsp.quot[15:0];
                        state_reg <= S_TSS;
                    end
                end
                S_TSS:
                begin
                    ds_reg    <= (lh2 >= 15'(hh)) ? 11'd0 : 11'(15'(hh) - lh2);
                    de_reg    <= (de_sum >= 16'(h_eff)) ? 11'(h_eff - 12'd1) : de_sum[10:0];
                    term_reg  <= (lh2 > 15'(hh)) ? lh2 - 15'(hh) : 15'd0;
                    wprod_reg <= 32'(perp_reg) * wmul_b;
                    if (lh_reg == '0)
                    begin
                        tstep_reg <= '1;
                        state_reg <= S_TEX;
                    end
                    else
                    begin
                        dreq_dvd_reg <= TEX_NUM;
                        dreq_dsr_reg <= DIV_DW'(lh_reg);
                        state_reg    <= S_TS;
                    end
                end
                S_TS:
                begin
                    if (div_rsp.done)
                    begin
                        tstep_reg <= (|div_rsp.quot[DIV_NW-1:22]) ? '1 : div_rsp.quot[21:0];
                        state_reg <= S_TEX;
                    end
                end
                S_TEX:
                begin
                    tx_reg <= (face_reg == FACE_EAST || face_reg == FACE_NORTH)
                              ? tx_mir[5:0] : tx_raw[5:0];
                    tpos_prod_reg <= 37'(term_reg) * 37'(tstep_reg);
                    state_reg     <= S_FIN;
                end
                S_FIN:
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || res.ready)
                    begin
                        res_reg <= '{out_column:  column_reg,
                                     hit:         hit_reg,
                                     face:        face_reg,
                                     perp_dist:   perp_reg,
                                     line_height: lh_reg,
                                     draw_start:  ds_reg,
                                     draw_end:    de_reg,
                                     tex_x:       tx_reg,
                                     tex_step:    tstep_reg,
                                     tex_pos:     (|tpos_prod_reg[36:32]) ? 32'hFFFF_FFFF
                                                  : tpos_prod_reg[31:0]};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !cmd.ready)
        else $error("command taken during map clearing pass");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_W'(MAX_STEPS))
        else $error("walk step count beyond limit");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !res.ready) |=> (state_reg == S_FIN))
        else $error("result dropped while output register full");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
`endif
endmodule

FILE: dv/grid_ray_cast_column_top_test.sv
// Self-checking test of the grid ray-cast column block: map writes, column casts
// and camera register settings, checked beat by beat against a local predictor.
// Depends on grc_pkg, grc_chan_if and grid_ray_cast_column_top.
module grid_ray_cast_column_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import grc_pkg::*;

    localparam int MAP_N      = 64;
    localparam int TEX_N      = 64;
    localparam int STEP_LIMIT = 128;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    grc_chan_if #(.T(cmd_t)) cmd_ch ();
    grc_chan_if #(.T(res_t)) res_ch ();
    grc_chan_if #(.T(cfg_t)) cfg_ch ();

    grid_ray_cast_column_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // Predictor state
    logic [21:0] cam_pos_x, cam_pos_y;
    logic [18:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
    logic [11:0] scr_w, scr_h;
    bit          wall_cells [MAP_N*MAP_N];

    res_t   pending_columns [$];
    int     mismatch_count = 0;
    int     results_seen = 0;
    bit     rx_idle_on = 1'b1;
    bit     tx_idle_on = 1'b1;
    int     rx_hold = 0;
    longint cycle_count = 0;

    function automatic longint fdiv16(longint v);
        if (v >= 0)
            return v >>> 16;
        return -((-v + 65535) >>> 16);
    endfunction

    function automatic longint sx19(logic [18:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit is_blocked(longint x, longint y);
        if (x < 0 || y < 0 || x >= MAP_N || y >= MAP_N)
            return 1'b1;
        return wall_cells[y*MAP_N + x];
    endfunction

    // Cast one column through the map, as the block does
    function automatic res_t cast_column(logic [10:0] col);
        res_t r;
        longint w, h, cam, rdx, rdy, px, py, mx, my, ddx, ddy, sxs, sys;
        longint sdx, sdy, num, rd, perp, lh, ds, de, wx, frac, tx, tstep, tpos;
        int side, hit_f;
        logic [1:0] fc;
        w = scr_w == 0 ? 1 : (scr_w > 2048 ? 2048 : scr_w);
        h = scr_h == 0 ? 1 : (scr_h > 2048 ? 2048 : scr_h);
        cam = ((longint'(col) * 2) << 16) / w - ONE_Q16;
        rdx = sx19(cam_dir_x) + fdiv16(sx19(cam_plane_x) * cam);
        rdy = sx19(cam_dir_y) + fdiv16(sx19(cam_plane_y) * cam);
        px = cam_pos_x;
        py = cam_pos_y;
        mx = px >>> 16;
        my = py >>> 16;
        ddx = rdx == 0 ? (64'd1 << 40) : (64'd1 << 32) / absl(rdx);
        ddy = rdy == 0 ? (64'd1 << 40) : (64'd1 << 32) / absl(rdy);
        sxs = rdx < 0 ? -1 : 1;
        sys = rdy < 0 ? -1 : 1;
        sdx = ((sxs < 0 ? (px & 16'hFFFF) : ONE_Q16 - (px & 16'hFFFF)) * ddx) >>> 16;
        sdy = ((sys < 0 ? (py & 16'hFFFF) : ONE_Q16 - (py & 16'hFFFF)) * ddy) >>> 16;
        side = 0;
        hit_f = 0;
        for (int n = 0; n < STEP_LIMIT && hit_f == 0; n++)
        begin
            if (sdx < sdy)
            begin
                sdx += ddx; mx += sxs; side = 0;
            end
            else
            begin
                sdy += ddy; my += sys; side = 1;
            end
            if (is_blocked(mx, my))
                hit_f = 1;
        end
        if (side == 0)
        begin
            num = mx*ONE_Q16 - px + (sxs < 0 ? ONE_Q16 : 0);
            rd = rdx;
            fc = sxs < 0 ? FACE_WEST : FACE_EAST;
        end
        else
        begin
            num = my*ONE_Q16 - py + (sys < 0 ? ONE_Q16 : 0);
            rd = rdy;
            fc = sys < 0 ? FACE_NORTH : FACE_SOUTH;
        end
        if (rd == 0)
            perp = 24'hFFFFFF;
        else
        begin
            perp = (absl(num) << 16) / absl(rd);
            if (perp > 24'hFFFFFF)
                perp = 24'hFFFFFF;
        end
        lh = perp == 0 ? 65535 : (h << 16) / perp;
        if (lh > 65535)
            lh = 65535;
        ds = h/2 - lh/2;
        if (ds < 0)
            ds = 0;
        de = lh/2 + h/2;
        if (de >= h)
            de = h - 1;
        wx = (side == 0 ? py : px) + fdiv16(perp * (side == 0 ? rdy : rdx));
        frac = wx & 16'hFFFF;
        tx = (frac * TEX_N) >>> 16;
        if (fc == FACE_EAST || fc == FACE_NORTH)
            tx = TEX_N - tx - 1;
        tstep = lh == 0 ? 22'h3FFFFF : (longint'(TEX_N) << 16) / lh;
        if (tstep > 22'h3FFFFF)
            tstep = 22'h3FFFFF;
        tpos = (ds - h/2 + lh/2) * tstep;
        if (tpos > 32'hFFFFFFFF)
            tpos = 32'hFFFFFFFF;
        r.out_column  = col;
        r.hit         = hit_f[0];
        r.face        = fc;
        r.perp_dist   = perp[23:0];
        r.line_height = lh[15:0];
        r.draw_start  = ds[10:0];
        r.draw_end    = de[10:0];
        r.tex_x       = tx[5:0];
        r.tex_step    = tstep[21:0];
        r.tex_pos     = tpos[31:0];
        return r;
    endfunction

    // Offer one command beat and update the predictor on acceptance;
    // valid stays high after the beat until the next one or cmd_idle
    task automatic send_cmd(cmd_t c);
        @(negedge clk);
        if (tx_idle_on && $urandom_range(3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        if (c.op == OP_WRITE)
            wall_cells[int'(c.cell_y)*MAP_N + int'(c.cell_x)] = c.wall;
        else
            pending_columns.push_back(cast_column(c.column));
    endtask

    // Drop command valid after the last beat of a sequence
    task automatic cmd_idle();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
    endtask

    task automatic send_write(int x, int y, bit w);
        cmd_t c;
        c = '0;
        c.op = OP_WRITE;
        c.cell_x = 6'(x);
        c.cell_y = 6'(y);
        c.wall = w;
        send_cmd(c);
    endtask

    task automatic send_cast(int col);
        cmd_t c;
        c.op = OP_CAST;
        c.column = 11'(col);
        c.cell_x = 6'($urandom);
        c.cell_y = 6'($urandom);
        c.wall = 1'($urandom);
        send_cmd(c);
    endtask

    // Wait for all casts to drain, then let the walk settle
    task automatic drain();
        cmd_idle();
        while (pending_columns.size() != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [21:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_POS_X:    cam_pos_x   = val;
            REG_POS_Y:    cam_pos_y   = val;
            REG_DIR_X:    cam_dir_x   = val[18:0];
            REG_DIR_Y:    cam_dir_y   = val[18:0];
            REG_PLANE_X:  cam_plane_x = val[18:0];
            REG_PLANE_Y:  cam_plane_y = val[18:0];
            REG_SCREEN_W: scr_w       = val[11:0];
            REG_SCREEN_H: scr_h       = val[11:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_camera(int px, int py, int dx, int dy, int plx, int ply, int w, int h);
        write_reg(REG_POS_X, 22'(px));
        write_reg(REG_POS_Y, 22'(py));
        write_reg(REG_DIR_X, 22'(dx));
        write_reg(REG_DIR_Y, 22'(dy));
        write_reg(REG_PLANE_X, 22'(plx));
        write_reg(REG_PLANE_Y, 22'(ply));
        write_reg(REG_SCREEN_W, 22'(w));
        write_reg(REG_SCREEN_H, 22'(h));
        cfg_ch.valid <= 1'b0;
    endtask

    // Build a walled room: the border of the square from lo to hi
    task automatic build_room(int lo, int hi);
        for (int i = lo; i <= hi; i++)
        begin
            send_write(i, lo, 1'b1);
            send_write(i, hi, 1'b1);
            send_write(lo, i, 1'b1);
            send_write(hi, i, 1'b1);
        end
        cmd_idle();
    endtask

    // Directed: reset camera, empty map edges, zero ray parts, extremes
    task automatic test_directed();
        send_cast(0);
        send_cast(320);
        send_cast(639);
        send_cast(2047);
        send_write(63, 63, 1'b1);
        send_write(0, 0, 1'b1);
        send_write(1, 2, 1'b1);
        send_write(1, 2, 1'b0);
        send_write(3, 2, 1'b1);
        send_cast(320);
        drain();
        // axis-aligned rays: zero components, zero screen sizes
        set_camera(32'h20_8000, 32'h20_8000, 32'h10000, 0, 0, 0, 0, 0);
        send_cast(0);
        send_cast(2047);
        drain();
        set_camera(0, 0, 0, 0, 0, 0, 4095, 4095);
        send_cast(0);
        send_cast(1024);
        drain();
        set_camera(22'h3FFFFF, 22'h3FFFFF, 19'h60000, 19'h20000, 19'h20000, 19'h60000, 1, 2048);
        send_cast(0);
        send_cast(1);
        drain();
        // diagonal ray from the map centre, walked until it hits a wall or the edge
        set_camera(32'h20_0000, 32'h20_0000, 19'h10000, 19'h10000, 0, 0, 2, 480);
        send_cast(1);
        drain();
    endtask

    // Random phases: room casts with random camera, plus noise writes
    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            if (p % 3 == 0)
                set_camera($urandom_range(0, 22'h3FFFFF), $urandom_range(0, 22'h3FFFFF),
                           $urandom_range(0, 19'h7FFFF), $urandom_range(0, 19'h7FFFF),
                           $urandom_range(0, 19'h7FFFF), $urandom_range(0, 19'h7FFFF),
                           $urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                set_camera($urandom_range(4 << 16, 28 << 16), $urandom_range(4 << 16, 28 << 16),
                           $urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                           $urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                           $urandom_range(1, 2048), $urandom_range(1, 2048));
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(4) == 0)
                    send_write($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom));
                else if ($urandom_range(7) == 0)
                    send_cast($urandom_range(0, 2047));
                else
                    send_cast($urandom_range(0, scr_w > 2047 ? 2047 : scr_w));
            end
            drain();
        end
    endtask

    // Receiver holds off while the sender keeps offering casts
    task automatic test_backpressure();
        rx_hold = 3000;
        for (int i = 0; i < 12; i++)
            send_cast($urandom_range(0, 639));
        drain();
    endtask

    // Receiver ready: random stalls, or a long hold when asked
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (rx_hold > 0)
        begin
            rx_hold--;
            res_ch.ready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(5) == 0)
        begin
            res_ch.ready <= 1'b0;
            rx_hold = $urandom_range(1, 12) - 1;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (pending_columns.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %p", res_ch.data);
            end
            else
            begin
                exp_r = pending_columns.pop_front();
                if (res_ch.data !== exp_r)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch col %0d\n  exp %p\n  got %p",
                                 exp_r.out_column, exp_r, res_ch.data);
                end
            end
        end
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        res_ch.ready = 1'b0;
        cam_pos_x = 163840;
        cam_pos_y = 163840;
        cam_dir_x = 19'h70000;
        cam_dir_y = 0;
        cam_plane_x = 0;
        cam_plane_y = 43254;
        scr_w = 640;
        scr_h = 480;
        foreach (wall_cells[i])
            wall_cells[i] = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        build_room(2, 30);
        test_random(8, 70);
        test_backpressure();
        test_random(5, 70);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random(2, 60);
        drain();
        if (mismatch_count == 0 && pending_columns.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
